[src/dct_2d_block_transform_defines.svh]
// Assertion macros used by the RTL controller
`ifndef DCT_2D_BLOCK_TRANSFORM_DEFINES_SVH
`define DCT_2D_BLOCK_TRANSFORM_DEFINES_SVH

`ifndef ASSERT_OFF

`define DCT2D_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DCT2D_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`else

`define DCT2D_ASSERT(name, clk, rst_n, prop, msg)

`define DCT2D_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)

`endif

`endif

[src/dct2d_pkg.sv]
`default_nettype none

package dct2d_pkg;

    localparam int BLOCK_SIZE = 4;
    localparam int ELEMS      = BLOCK_SIZE * BLOCK_SIZE;
    localparam int K_W        = $clog2(BLOCK_SIZE);
    localparam int IDX_W      = $clog2(ELEMS);
    localparam int MEM_DEPTH  = 2 * ELEMS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int SEQ_W      = IDX_W + K_W;

    localparam int SAMPLE_W   = 16;
    localparam int WORD_W     = 32;
    localparam int COEF_W     = 15;
    localparam int PROD_W     = WORD_W + COEF_W;
    localparam int ACC_W      = PROD_W + K_W;
    localparam int OUT_W      = 20;
    localparam int FRAC_SHIFT = 24;

    localparam int OBUF_DEPTH = 2;
    localparam int CREDIT_W   = $clog2(OBUF_DEPTH + 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [OUT_W-1:0]    t_result;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [K_W-1:0]             t_k;

    localparam t_idx LAST_IDX = IDX_W'(ELEMS - 1);

    // orthonormal DCT-II basis, Q1.14, row = frequency, column = position
    localparam t_coef BASIS [BLOCK_SIZE][BLOCK_SIZE] = '{
        '{ 15'sd8192,   15'sd8192,   15'sd8192,   15'sd8192 },
        '{ 15'sd10703,  15'sd4433,  -15'sd4433,  -15'sd10703 },
        '{ 15'sd8192,  -15'sd8192,  -15'sd8192,   15'sd8192 },
        '{ 15'sd4433,  -15'sd10703,  15'sd10703, -15'sd4433 }
    };

    // one multiply-accumulate beat
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic pass2;
        t_idx dest;
    } t_mac_op;

    // memory write port
    typedef struct packed {
        logic  valid;
        t_addr addr;
        t_word data;
    } t_wr;

    // finished result word
    typedef struct packed {
        logic    valid;
        t_result coefficient;
        logic    last;
    } t_res;

endpackage

`default_nettype wire

[src/dct2d_ifs.sv]
`default_nettype none

interface dct2d_sample_if;
    import dct2d_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface dct2d_coef_if;
    import dct2d_pkg::*;
    logic    valid;
    logic    ready;
    t_result coefficient;
    logic    last;
    modport source (output valid, output coefficient, output last, input ready);
    modport sink (input valid, input coefficient, input last, output ready);
endinterface

interface dct2d_cfg_if;
    logic valid;
    logic ready;
    logic direction;
    modport source (output valid, output direction, input ready);
    modport sink (input valid, input direction, output ready);
endinterface

`default_nettype wire

[src/dct2d_ram.sv]
`default_nettype none

module dct2d_ram #(
    parameter int WIDTH = dct2d_pkg::WORD_W,
    parameter int DEPTH = dct2d_pkg::MEM_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/dct2d_ctrl.sv]
`default_nettype none
`include "dct_2d_block_transform_defines.svh"

module dct2d_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    dct2d_sample_if.sink            i_sample,
    dct2d_cfg_if.sink               i_cfg,
    input  wire dct2d_pkg::t_wr     i_wb,
    input  wire logic               i_out_pop,
    output dct2d_pkg::t_wr          o_mem_wr,
    output dct2d_pkg::t_addr        o_raddr,
    output dct2d_pkg::t_coef        o_weight,
    output dct2d_pkg::t_mac_op      o_op
);

    import dct2d_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_PASS1,
        S_PASS2
    } t_state;

    localparam logic [SEQ_W-1:0]    LAST_SEQ = '1;
    localparam logic [CREDIT_W-1:0] CREDIT_FULL = CREDIT_W'(OBUF_DEPTH);

    t_state              r_state, n_state;
    t_idx                r_load_cnt, n_load_cnt;
    logic [SEQ_W-1:0]    r_cnt, n_cnt;
    logic                r_direction, n_direction;
    logic                r_inverse, n_inverse;
    logic [CREDIT_W-1:0] r_credit, n_credit;

    t_k   seq_hi, seq_mid, seq_k, w_row;
    logic in_fire, cfg_fire, issue, credit_take;

    assign {seq_hi, seq_mid, seq_k} = r_cnt;

    assign i_sample.ready = (r_state == S_LOAD);
    assign i_cfg.ready    = 1'b1;
    assign in_fire        = i_sample.valid & i_sample.ready;
    assign cfg_fire       = i_cfg.valid & i_cfg.ready;

    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_cnt       = r_cnt;
        n_direction = cfg_fire ? i_cfg.direction : r_direction;
        n_inverse   = r_inverse;
        issue       = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    if (r_load_cnt == LAST_IDX) begin
                        n_load_cnt = '0;
                        n_inverse  = n_direction;
                        n_cnt      = '0;
                        n_state    = S_PASS1;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            S_PASS1: begin
                issue = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SEQ) begin
                    n_state = S_PASS2;
                end
            end
            S_PASS2: begin
                // a result group starts only with room reserved in the output buffer
                issue = (seq_k != '0) || (r_credit != CREDIT_FULL);
                if (issue) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == LAST_SEQ) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign credit_take = issue && (r_state == S_PASS2) && (seq_k == '0);

    always_comb begin
        unique case ({credit_take, i_out_pop})
            2'b10:   n_credit = r_credit + 1'b1;
            2'b01:   n_credit = r_credit - 1'b1;
            default: n_credit = r_credit;
        endcase
    end

    // pass one: T[a][d] = sum_c W[a][c] X[c][d]; pass two: Y[a][b] = sum_d W[b][d] T[a][d]
    assign w_row    = (r_state == S_PASS2) ? seq_mid : seq_hi;
    assign o_weight = r_inverse ? BASIS[seq_k][w_row] : BASIS[w_row][seq_k];
    assign o_raddr  = (r_state == S_PASS2) ? {1'b1, seq_hi, seq_k} : {1'b0, seq_k, seq_mid};

    always_comb begin
        o_op.valid = issue;
        o_op.first = (seq_k == '0);
        o_op.last  = (seq_k == '1);
        o_op.pass2 = (r_state == S_PASS2);
        o_op.dest  = {seq_hi, seq_mid};
    end

    always_comb begin
        if (in_fire) begin
            o_mem_wr.valid = 1'b1;
            o_mem_wr.addr  = {1'b0, r_load_cnt};
            o_mem_wr.data  = WORD_W'(i_sample.sample);
        end else begin
            o_mem_wr = i_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_cnt  <= '0;
            r_cnt       <= '0;
            r_direction <= 1'b0;
            r_inverse   <= 1'b0;
            r_credit    <= '0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_cnt       <= n_cnt;
            r_direction <= n_direction;
            r_inverse   <= n_inverse;
            r_credit    <= n_credit;
        end
    end

    `DCT2D_ASSERT(a_wb_not_loading, i_clk, i_rst_n, i_wb.valid |-> r_state != S_LOAD, "write-back overlaps sample load")
    `DCT2D_ASSERT(a_credit_bound, i_clk, i_rst_n, r_credit <= CREDIT_FULL, "output credit overflow")
    `DCT2D_ASSERT(a_pop_reserved, i_clk, i_rst_n, i_out_pop |-> r_credit != '0, "output word without reserved credit")
    `DCT2D_ASSERT_NEXT(a_block_start, i_clk, i_rst_n, in_fire && r_load_cnt == LAST_IDX, r_state == S_PASS1 && r_cnt == '0, "block did not start after final sample")

endmodule

`default_nettype wire

[src/dct2d_mac.sv]
`default_nettype none

module dct2d_mac (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dct2d_pkg::t_mac_op i_op,
    input  wire dct2d_pkg::t_coef   i_weight,
    input  wire dct2d_pkg::t_word   i_rdata,
    output dct2d_pkg::t_wr          o_wb,
    output dct2d_pkg::t_res         o_res
);

    import dct2d_pkg::*;

    localparam t_acc ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam t_acc SAT_MAX    = ACC_W'(2 ** (OUT_W - 1) - 1);
    localparam t_acc SAT_MIN    = -SAT_MAX - ACC_W'(1);

    t_mac_op r_s1_op, r_s2_op, r_s3_op;
    t_coef   r_s1_w;
    t_prod   r_prod;
    t_acc    r_acc;

    t_acc    round_sum, scaled;
    t_result sat;
    logic    done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op <= '0;
            r_s2_op <= '0;
            r_s3_op <= '0;
        end else begin
            r_s1_op <= i_op;
            r_s2_op <= r_s1_op;
            r_s3_op <= r_s2_op;
        end
        r_s1_w <= i_weight;
        r_prod <= PROD_W'(i_rdata) * PROD_W'(r_s1_w);
        if (r_s2_op.valid) begin
            r_acc <= (r_s2_op.first ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    assign done = r_s3_op.valid && r_s3_op.last;

    // round half away from zero: floor((acc + half - sign) / 2^24)
    assign round_sum = r_acc + ROUND_HALF - ACC_W'({1'b0, r_acc[ACC_W-1]});
    assign scaled    = round_sum >>> FRAC_SHIFT;

    always_comb begin
        if (scaled > SAT_MAX) begin
            sat = OUT_W'(SAT_MAX);
        end else if (scaled < SAT_MIN) begin
            sat = OUT_W'(SAT_MIN);
        end else begin
            sat = OUT_W'(scaled);
        end
    end

    always_comb begin
        o_wb.valid = done && !r_s3_op.pass2;
        o_wb.addr  = {1'b1, r_s3_op.dest};
        o_wb.data  = WORD_W'(r_acc);

        o_res.valid       = done && r_s3_op.pass2;
        o_res.coefficient = sat;
        o_res.last        = (r_s3_op.dest == LAST_IDX);
    end

endmodule

`default_nettype wire

[src/dct2d_obuf.sv]
`default_nettype none

module dct2d_obuf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dct2d_pkg::t_res i_res,
    dct2d_coef_if.source         o_coef
);

    import dct2d_pkg::*;

    localparam int PTR_W = $clog2(OBUF_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(OBUF_DEPTH - 1);

    t_result             r_coef [OBUF_DEPTH];
    logic                r_last [OBUF_DEPTH];
    logic [PTR_W-1:0]    r_wp, r_rp;
    logic [CREDIT_W-1:0] r_count;
    logic                pop;

    assign o_coef.valid       = (r_count != '0);
    assign o_coef.coefficient = r_coef[r_rp];
    assign o_coef.last        = r_last[r_rp];
    assign pop                = o_coef.valid & o_coef.ready;

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_coef[r_wp] <= i_res.coefficient;
            r_last[r_wp] <= i_res.last;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_res.valid) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_res.valid, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/dct_2d_block_transform.sv]
`default_nettype none
// 4x4 orthonormal 2D DCT-II / DCT-III, one shared multiply-accumulate unit, one data RAM.
// Load: one sample word per cycle while in the load state, 16 samples per block.
// Compute: column pass then row pass, 64 MAC beats each, one MAC beat per RAM read.
// The next block loads while results drain; no samples are taken during either pass.
// Reset: clears sequencer, output buffer and direction (forward); RAM contents are kept.

module dct_2d_block_transform (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    dct2d_sample_if.sink   i_sample,
    dct2d_coef_if.source   o_coef,
    dct2d_cfg_if.sink      i_cfg
);

    import dct2d_pkg::*;

    t_wr     mem_wr;
    t_wr     wb;
    t_addr   raddr;
    t_word   rdata;
    t_coef   weight;
    t_mac_op op;
    t_res    res;
    logic    out_pop;

    assign out_pop = o_coef.valid & o_coef.ready;

    dct2d_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (i_sample),
        .i_cfg     (i_cfg),
        .i_wb      (wb),
        .i_out_pop (out_pop),
        .o_mem_wr  (mem_wr),
        .o_raddr   (raddr),
        .o_weight  (weight),
        .o_op      (op)
    );

    dct2d_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_wr.valid),
        .i_waddr (mem_wr.addr),
        .i_wdata (mem_wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dct2d_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_weight (weight),
        .i_rdata  (rdata),
        .o_wb     (wb),
        .o_res    (res)
    );

    dct2d_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_coef  (o_coef)
    );

endmodule

`default_nettype wire
